FILE: rtl/twc_pkg.sv
// Shared constants and types for the triangle waterline clipper.
package twc_pkg;

	localparam int COORD_BITS_DEF = 32;

	typedef enum logic [1:0] {
		KIND_WHOLE = 2'd0,
		KIND_ONE   = 2'd1,
		KIND_TWO   = 2'd2
	} clip_kind_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: rtl/twc_front.sv
// Front end: classifies a triangle and orders its vertices for the cut unit.
module twc_front
	import twc_pkg::*;
#(
	parameter int CB = COORD_BITS_DEF,
	localparam int VW = 4 * CB,
	localparam int EW = 2 + 4 * VW
) (
	input  logic          start,
	input  q_status_t     qstat,
	input  logic [VW-1:0] vtx0,
	input  logic [VW-1:0] vtx1,
	input  logic [VW-1:0] vtx2,
	output logic          push,
	output logic [EW-1:0] entry
);

	logic [2:0]    under;
	logic [1:0]    lone;
	logic [VW-1:0] r0, r1, r2;
	logic [VW-1:0] p0, p1, p2, p3;
	clip_kind_t    kind;

	assign under = {vtx2[VW-1], vtx1[VW-1], vtx0[VW-1]};

	always_comb begin
		kind = KIND_WHOLE;
		lone = 2'd0;
		unique case (under)
			3'b001: begin kind = KIND_ONE; lone = 2'd0; end
			3'b010: begin kind = KIND_ONE; lone = 2'd1; end
			3'b100: begin kind = KIND_ONE; lone = 2'd2; end
			3'b110: begin kind = KIND_TWO; lone = 2'd0; end
			3'b101: begin kind = KIND_TWO; lone = 2'd1; end
			3'b011: begin kind = KIND_TWO; lone = 2'd2; end
			default: begin kind = KIND_WHOLE; lone = 2'd0; end
		endcase
	end

	always_comb begin
		unique case (lone)
			2'd1: begin r0 = vtx1; r1 = vtx2; r2 = vtx0; end
			2'd2: begin r0 = vtx2; r1 = vtx0; r2 = vtx1; end
			default: begin r0 = vtx0; r1 = vtx1; r2 = vtx2; end
		endcase
	end

	always_comb begin
		unique case (kind)
			KIND_ONE: begin p0 = r0; p1 = r2; p2 = r0; p3 = r1; end
			KIND_TWO: begin p0 = r2; p1 = r0; p2 = r1; p3 = r0; end
			default: begin p0 = vtx0; p1 = vtx1; p2 = vtx2; p3 = vtx0; end
		endcase
	end

	assign entry = {kind, p3, p2, p1, p0};
	assign push  = start & ~qstat.full & (under != 3'b000);

endmodule

FILE: rtl/twc_fifo.sv
// Two-entry queue between the classifier and the cut unit.
module twc_fifo
	import twc_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output q_status_t    qstat
);

	logic [W-1:0] mem_q [2];
	logic         wptr_q, rptr_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign rdata       = mem_q[rptr_q];
	assign qstat.full  = cnt_q[1];
	assign qstat.empty = (cnt_q == 2'd0);

endmodule

FILE: rtl/twc_back.sv
// Cut unit: edge crossings by multiply and restoring divide, then emission.
module twc_back
	import twc_pkg::*;
#(
	parameter int CB = COORD_BITS_DEF,
	localparam int VW = 4 * CB,
	localparam int EW = 2 + 4 * VW,
	localparam int CW = $clog2(CB + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  q_status_t       qstat,
	input  logic [EW-1:0]   head,
	output logic            pop,
	output logic            out_valid,
	output logic [9*CB-1:0] out_pts,
	output clip_kind_t      out_kind,
	output logic            out_last
);

	typedef enum logic [1:0] {S_IDLE, S_SETUP, S_MUL, S_DIV} state_t;

	state_t          state_q;
	logic [EW-1:0]   entry_q;
	logic            sel_q;
	logic [CW-1:0]   cnt_q;
	logic [CB-1:0]   num_q, den_q;
	logic [CB-1:0]   mag_q  [3];
	logic [CB-1:0]   base_q [3];
	logic [2:0]      neg_q;
	logic [2*CB-1:0] work_q [3];
	logic [3*CB-1:0] c1_q;
	logic [3*CB-1:0] c2_q;
	logic            emit2_q;
	logic            valid_q;
	logic [9*CB-1:0] pts_q;
	clip_kind_t      kind_q;
	logic            last_q;

	logic [VW-1:0]   pu, pq;
	logic [2*CB-1:0] work_nx [3];
	logic [3*CB-1:0] res;
	logic [3*CB-1:0] hp0, hp1, hp2, e0, e2;
	clip_kind_t      ekind, hkind;

	assign pu = sel_q ? entry_q[2*VW +: VW] : entry_q[0 +: VW];
	assign pq = sel_q ? entry_q[3*VW +: VW] : entry_q[VW +: VW];
	assign e0 = entry_q[0 +: 3*CB];
	assign e2 = entry_q[2*VW +: 3*CB];
	assign hp0 = head[0 +: 3*CB];
	assign hp1 = head[VW +: 3*CB];
	assign hp2 = head[2*VW +: 3*CB];
	assign ekind = clip_kind_t'(entry_q[EW-1 -: 2]);
	assign hkind = clip_kind_t'(head[EW-1 -: 2]);
	assign pop = (state_q == S_IDLE) & ~emit2_q & ~qstat.empty;

	always_comb begin
		logic [CB:0] trial;
		logic [CB-1:0] qv;
		for (int i = 0; i < 3; i++) begin
			trial = {work_q[i][2*CB-1:CB], work_q[i][2*CB-1-CB]};
			if (trial >= {1'b0, den_q}) begin
				work_nx[i] = {trial[CB-1:0] - den_q, work_q[i][CB-2:0], 1'b1};
			end else begin
				work_nx[i] = {trial[CB-1:0], work_q[i][CB-2:0], 1'b0};
			end
			qv = work_nx[i][CB-1:0];
			res[i*CB +: CB] = base_q[i] + (neg_q[i] ? (~qv + 1'b1) : qv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 1'b0;
			cnt_q   <= '0;
			emit2_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (emit2_q) begin
						emit2_q <= 1'b0;
						valid_q <= 1'b1;
						pts_q   <= {c2_q, c1_q, e2};
						kind_q  <= KIND_TWO;
						last_q  <= 1'b1;
					end else if (!qstat.empty) begin
						entry_q <= head;
						if (hkind == KIND_WHOLE) begin
							valid_q <= 1'b1;
							pts_q   <= {hp2, hp1, hp0};
							kind_q  <= KIND_WHOLE;
							last_q  <= 1'b1;
						end else begin
							sel_q   <= 1'b0;
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					logic [CB:0] diff;
					for (int i = 0; i < 3; i++) begin
						diff = {pq[i*CB+CB-1], pq[i*CB +: CB]}
							- {pu[i*CB+CB-1], pu[i*CB +: CB]};
						neg_q[i]  <= diff[CB];
						mag_q[i]  <= diff[CB] ? (~diff[CB-1:0] + 1'b1) : diff[CB-1:0];
						base_q[i] <= pu[i*CB +: CB];
					end
					num_q   <= ~pu[3*CB +: CB] + 1'b1;
					den_q   <= pq[3*CB +: CB] - pu[3*CB +: CB];
					state_q <= S_MUL;
				end
				S_MUL: begin
					for (int i = 0; i < 3; i++) begin
						work_q[i] <= mag_q[i] * num_q;
					end
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					for (int i = 0; i < 3; i++) begin
						work_q[i] <= work_nx[i];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(CB - 1)) begin
						if (!sel_q) begin
							c1_q    <= res;
							sel_q   <= 1'b1;
							state_q <= S_SETUP;
						end else begin
							c2_q    <= res;
							valid_q <= 1'b1;
							kind_q  <= ekind;
							state_q <= S_IDLE;
							if (ekind == KIND_ONE) begin
								pts_q  <= {res, e0, c1_q};
								last_q <= 1'b1;
							end else begin
								pts_q   <= {c1_q, e0, e2};
								last_q  <= 1'b0;
								emit2_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = valid_q;
	assign out_pts   = pts_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |=> valid_q && last_q)
		else $error("second cut triangle did not follow the first");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty && state_q == S_IDLE)
		else $error("queue read while empty or busy");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |=> state_q == S_DIV && cnt_q == '0)
		else $error("divide did not start after multiply");

endmodule

FILE: rtl/triangle_waterline_clipper_unit.sv
// Top level of the triangle waterline clipper.
// A triangle is transferred on the rising edge where start is high and busy is
// low; its twelve fields (three vertices with x, y, z and surface distance) are
// sampled at that edge. A vertex with negative distance is under water.
// The submerged part leaves as zero, one or two triangles, each shown on the
// result ports for exactly one cycle with result_valid high; last_of_run marks
// the final triangle of a transfer. A triangle with all vertices above water
// produces nothing.
// A classifier writes into a two-entry queue; busy is high while it is full.
// A fully submerged triangle passes through the queue and the output register,
// and such triangles stream at one per cycle while no cut triangle is in work.
// A cut triangle computes two crossing points one after the other, each through
// a setup state, a multiply state and the divide state of a restoring divider
// that works on the three coordinates in parallel; the second result of a
// two-vertex cut follows in the next cycle.
// Reset clears the queue and the controller. The block itself does not stall its
// output: no item is lost only if the receiver takes every result as it appears.
module triangle_waterline_clipper_unit
	import twc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_BITS-1:0] v0_x,
	input  logic [COORD_BITS-1:0] v0_y,
	input  logic [COORD_BITS-1:0] v0_z,
	input  logic [COORD_BITS-1:0] v0_dist,
	input  logic [COORD_BITS-1:0] v1_x,
	input  logic [COORD_BITS-1:0] v1_y,
	input  logic [COORD_BITS-1:0] v1_z,
	input  logic [COORD_BITS-1:0] v1_dist,
	input  logic [COORD_BITS-1:0] v2_x,
	input  logic [COORD_BITS-1:0] v2_y,
	input  logic [COORD_BITS-1:0] v2_z,
	input  logic [COORD_BITS-1:0] v2_dist,
	output logic                  result_valid,
	output logic [COORD_BITS-1:0] pa_x,
	output logic [COORD_BITS-1:0] pa_y,
	output logic [COORD_BITS-1:0] pa_z,
	output logic [COORD_BITS-1:0] pb_x,
	output logic [COORD_BITS-1:0] pb_y,
	output logic [COORD_BITS-1:0] pb_z,
	output logic [COORD_BITS-1:0] pc_x,
	output logic [COORD_BITS-1:0] pc_y,
	output logic [COORD_BITS-1:0] pc_z,
	output logic [1:0]            clip_kind,
	output logic                  last_of_run
);

	localparam int CB = COORD_BITS;
	localparam int EW = 2 + 16 * CB;

	q_status_t       qstat;
	logic            push, pop;
	logic [EW-1:0]   entry, head;
	logic [9*CB-1:0] pts;
	clip_kind_t      kind;

	twc_front #(.CB(CB)) u_front (
		.start (start),
		.qstat (qstat),
		.vtx0  ({v0_dist, v0_z, v0_y, v0_x}),
		.vtx1  ({v1_dist, v1_z, v1_y, v1_x}),
		.vtx2  ({v2_dist, v2_z, v2_y, v2_x}),
		.push  (push),
		.entry (entry)
	);

	twc_fifo #(.W(EW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head),
		.qstat  (qstat)
	);

	twc_back #(.CB(CB)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (result_valid),
		.out_pts   (pts),
		.out_kind  (kind),
		.out_last  (last_of_run)
	);

	assign busy      = qstat.full;
	assign clip_kind = kind;
	assign pa_x = pts[0*CB +: CB];
	assign pa_y = pts[1*CB +: CB];
	assign pa_z = pts[2*CB +: CB];
	assign pb_x = pts[3*CB +: CB];
	assign pb_y = pts[4*CB +: CB];
	assign pb_z = pts[5*CB +: CB];
	assign pc_x = pts[6*CB +: CB];
	assign pc_y = pts[7*CB +: CB];
	assign pc_z = pts[8*CB +: CB];

endmodule

FILE: tb/sv/triangle_waterline_clipper_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the triangle waterline clipper: directed and random triangles.
module triangle_waterline_clipper_unit_tb
	import twc_pkg::*;
;

	localparam int CB = 32;
	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		coord_t x, y, z, d;
	} vertex_t;

	typedef struct {
		vertex_t v[3];
	} tri_t;

	typedef struct {
		coord_t p[9];
		clip_kind_t kind;
		logic last;
	} piece_t;

	typedef struct {
		tri_t t;
		logic known;
		piece_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	coord_t vin[12];
	logic result_valid;
	logic [CB-1:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z, pc_x, pc_y, pc_z;
	logic [1:0] clip_kind;
	logic last_of_run;

	piece_t expected_pieces[$];
	piece_t typed_pieces[$];
	int errors = 0;

	always #6 clk = ~clk;

	initial
		foreach (vin[i]) vin[i] = '0;

	triangle_waterline_clipper_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.v0_x(vin[0]), .v0_y(vin[1]), .v0_z(vin[2]), .v0_dist(vin[3]),
		.v1_x(vin[4]), .v1_y(vin[5]), .v1_z(vin[6]), .v1_dist(vin[7]),
		.v2_x(vin[8]), .v2_y(vin[9]), .v2_z(vin[10]), .v2_dist(vin[11]),
		.result_valid(result_valid),
		.pa_x(pa_x), .pa_y(pa_y), .pa_z(pa_z), .pb_x(pb_x), .pb_y(pb_y), .pb_z(pb_z),
		.pc_x(pc_x), .pc_y(pc_y), .pc_z(pc_z),
		.clip_kind(clip_kind), .last_of_run(last_of_run)
	);

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic coord_t waterline_point(input coord_t p, input coord_t q,
			input coord_t dp, input coord_t dq);
		logic signed [CB+1:0] diff;
		logic [CB+1:0] mag;
		logic [CB:0] num, den;
		logic [2*CB+2:0] prod;
		logic [CB+1:0] off;
		diff = $signed({{2{q[CB-1]}}, q}) - $signed({{2{p[CB-1]}}, p});
		mag = diff < 0 ? -diff : diff;
		num = -$signed({dp[CB-1], dp});
		den = $signed({dq[CB-1], dq}) - $signed({dp[CB-1], dp});
		prod = mag * num;
		off = prod / den;
		return diff < 0 ? p - coord_t'(off) : p + coord_t'(off);
	endfunction

	function automatic vertex_t cut_edge(input vertex_t a, input vertex_t b);
		vertex_t r;
		r.x = waterline_point(a.x, b.x, a.d, b.d);
		r.y = waterline_point(a.y, b.y, a.d, b.d);
		r.z = waterline_point(a.z, b.z, a.d, b.d);
		r.d = '0;
		return r;
	endfunction

	function automatic piece_t make_piece(input vertex_t a, input vertex_t b, input vertex_t c,
			input clip_kind_t kind, input logic last);
		piece_t r;
		r.p = '{a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z};
		r.kind = kind;
		r.last = last;
		return r;
	endfunction

	task automatic predict_submerged(input tri_t t);
		int under, lone, m, w;
		under = 0;
		lone = 0;
		for (int i = 0; i < 3; i++)
			if (t.v[i].d < 0) under++;
		for (int i = 0; i < 3; i++)
			if ((under == 1 && t.v[i].d < 0) || (under == 2 && t.v[i].d >= 0)) lone = i;
		m = (lone + 1) % 3;
		w = (lone + 2) % 3;
		if (under == 3) begin
			expected_pieces.push_back(make_piece(t.v[0], t.v[1], t.v[2], KIND_WHOLE, 1'b1));
		end else if (under == 1) begin
			expected_pieces.push_back(make_piece(cut_edge(t.v[lone], t.v[w]), t.v[lone],
				cut_edge(t.v[lone], t.v[m]), KIND_ONE, 1'b1));
		end else if (under == 2) begin
			expected_pieces.push_back(make_piece(t.v[m], t.v[w], cut_edge(t.v[w], t.v[lone]),
				KIND_TWO, 1'b0));
			expected_pieces.push_back(make_piece(t.v[m], cut_edge(t.v[w], t.v[lone]),
				cut_edge(t.v[m], t.v[lone]), KIND_TWO, 1'b1));
		end
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return coord_t'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
		endcase
	endfunction

	function automatic coord_t rand_dist();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return coord_t'($urandom);
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			3: return $urandom_range(0, 1) ? 32'sh1 : -32'sh1;
			default: return coord_t'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000);
		endcase
	endfunction

	function automatic tri_t rand_tri();
		tri_t t;
		for (int i = 0; i < 3; i++) begin
			t.v[i].x = rand_coord();
			t.v[i].y = rand_coord();
			t.v[i].z = rand_coord();
			t.v[i].d = rand_dist();
		end
		return t;
	endfunction

	function automatic tri_t mk_tri(input coord_t c0, input coord_t c1, input coord_t c2,
			input coord_t d0, input coord_t d1, input coord_t d2);
		tri_t t;
		t.v[0] = '{c0, c0, c0, d0};
		t.v[1] = '{c1, -c1, c1, d1};
		t.v[2] = '{c2, c2, -c2, d2};
		return t;
	endfunction

	task automatic transfer_triangle(input tri_t t);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		for (int i = 0; i < 3; i++) begin
			vin[4*i] <= t.v[i].x;
			vin[4*i+1] <= t.v[i].y;
			vin[4*i+2] <= t.v[i].z;
			vin[4*i+3] <= t.v[i].d;
		end
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (typed_pieces.size() != 0)
			expected_pieces.push_back(typed_pieces.pop_front());
		else
			predict_submerged(t);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		piece_t exp_p;
		logic [CB-1:0] got[9];
		if (arst_n && result_valid) begin
			got = '{pa_x, pa_y, pa_z, pb_x, pb_y, pb_z, pc_x, pc_y, pc_z};
			if (expected_pieces.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				exp_p = expected_pieces.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== exp_p.p[k])
						report_mismatch($sformatf("point field %0d got %h want %h",
							k, got[k], exp_p.p[k]));
				if (clip_kind !== exp_p.kind)
					report_mismatch($sformatf("clip_kind got %0d want %0d", clip_kind, exp_p.kind));
				if (last_of_run !== exp_p.last)
					report_mismatch($sformatf("last_of_run got %b want %b",
						last_of_run, exp_p.last));
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		coord_t mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		r.known = 1'b0;
		r.t = mk_tri(mx, mn, 0, -1, -1, -1);
		r.known = 1'b1;
		r.res = make_piece(r.t.v[0], r.t.v[1], r.t.v[2], KIND_WHOLE, 1'b1);
		rows.push_back(r);
		r.known = 1'b0;
		r.t = mk_tri(mx, mn, 5, 0, 0, 0);
		rows.push_back(r);
		r.t = mk_tri(mx, mn, 5, mx, mx, mx);
		rows.push_back(r);
		r.t = mk_tri(mn, mx, 0, mn, mn, mn);
		rows.push_back(r);
		for (int i = 0; i < 3; i++) begin
			r.t = mk_tri(mn, mx, 32'sh10000, i == 0 ? mn : mx, i == 1 ? mn : mx,
				i == 2 ? mn : mx);
			rows.push_back(r);
			r.t = mk_tri(32'sh20000, -32'sh30000, mx, i == 0 ? -1 : 0, i == 1 ? -1 : 0,
				i == 2 ? -1 : 0);
			rows.push_back(r);
			r.t = mk_tri(mx, mn, -32'sh1234, i == 0 ? 0 : -32'sh8000, i == 1 ? 0 : -32'sh8000,
				i == 2 ? 0 : -32'sh8000);
			rows.push_back(r);
			r.t = mk_tri(mn, mx, 32'sh777, i == 0 ? mx : mn, i == 1 ? mx : mn,
				i == 2 ? mx : mn);
			rows.push_back(r);
			r.t = mk_tri(mn, mn, mx, i == 0 ? 1 : -1, i == 1 ? 1 : -1, i == 2 ? 1 : -1);
			rows.push_back(r);
		end
		r.t = mk_tri(-1, 0, 1, -1, -1, -1);
		rows.push_back(r);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			if (rows[i].known) typed_pieces.push_back(rows[i].res);
			transfer_triangle(rows[i].t);
		end
		repeat (1400) transfer_triangle(rand_tri());
		start <= 1'b0;
		while (expected_pieces.size() != 0) @(posedge clk);
		repeat (2 * (CB + 2) + 10) @(posedge clk);
		if (errors == 0 && typed_pieces.size() == 0)
			$display("PASS triangle_waterline_clipper_unit");
		else
			$display("FAIL triangle_waterline_clipper_unit");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAIL triangle_waterline_clipper_unit");
		$finish;
	end

endmodule

FILE: triangle_waterline_clipper_unit.f
rtl/twc_pkg.sv
rtl/twc_front.sv
rtl/twc_fifo.sv
rtl/twc_back.sv
rtl/triangle_waterline_clipper_unit.sv
tb/sv/triangle_waterline_clipper_unit_tb.sv
